// ===== sv/mppa_pkg.sv =====
// ----------------------------------------------------------------------------
// mppa_pkg
// Shared widths, reset values and register codes of the masked-pixel
// premultiplier.
// ----------------------------------------------------------------------------
package mppa_pkg;

	localparam int unsigned PIX_W    = 32;
	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned SHIFT_W  = 5;
	localparam int unsigned NUM_CHAN = 3;
	localparam int unsigned SQ_W     = 2 * CHAN_W;
	// 4 * c * c * a
	localparam int unsigned X_W      = 3 * CHAN_W + 2;
	// largest m with 255 * m * m <= x is at most 510
	localparam int unsigned ROOT_W   = CHAN_W + 1;

	localparam int unsigned ROOT_PER_STAGE = 2;
	localparam int unsigned ROOT_STAGES    = (ROOT_W + ROOT_PER_STAGE - 1) / ROOT_PER_STAGE;
	localparam int unsigned FRONT_STAGES   = 3;
	localparam int unsigned NUM_STAGES     = FRONT_STAGES + ROOT_STAGES;

	localparam logic [PIX_W-1:0] RED_MASK_RST   = 32'h00FF_0000;
	localparam logic [PIX_W-1:0] GREEN_MASK_RST = 32'h0000_FF00;
	localparam logic [PIX_W-1:0] BLUE_MASK_RST  = 32'h0000_00FF;

	localparam logic [SHIFT_W-1:0] RED_SHIFT_RST   = 5'd16;
	localparam logic [SHIFT_W-1:0] GREEN_SHIFT_RST = 5'd8;
	localparam logic [SHIFT_W-1:0] BLUE_SHIFT_RST  = 5'd0;
	localparam logic [SHIFT_W-1:0] ALPHA_SHIFT_RST = 5'd24;

	typedef enum logic [1:0] {
		REG_RED   = 2'd0,
		REG_GREEN = 2'd1,
		REG_BLUE  = 2'd2
	} cfg_reg_t;

	// index of lowest set bit, 0 when none
	function automatic logic [SHIFT_W-1:0] low_bit(input logic [PIX_W-1:0] m);
		logic [SHIFT_W-1:0] idx;
		idx = '0;
		for (int i = PIX_W - 1; i >= 0; i--) begin
			if (m[i]) begin
				idx = SHIFT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== sv/mask_pixel_premultiply_alpha.sv =====
// ----------------------------------------------------------------------------
// mask_pixel_premultiply_alpha
// Masked 32-bit pixel to premultiplied ARGB8888 (gamma-2 premultiply).
// ----------------------------------------------------------------------------
// Takes one pixel per cycle unless in_stall holds it back, and returns one
// ARGB8888 item for each, in order. The stages are: channel extract, square,
// times alpha, then a five-stage root that resolves two of its nine result
// bits per stage (one in the last stage). Channel positions
// come from the red, green and blue masks (alpha is what none of them covers);
// shifts and the mask error flag are worked out when a mask is written, so
// masks should only be changed with the pipeline empty.
module mask_pixel_premultiply_alpha (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [mppa_pkg::PIX_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mppa_pkg::PIX_W-1:0]    source_pixel,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mppa_pkg::PIX_W-1:0]    packed_pixel,
	output logic                          mask_error
);

	localparam int unsigned NS = mppa_pkg::NUM_STAGES;
	localparam int unsigned FS = mppa_pkg::FRONT_STAGES;

	// configuration
	logic [mppa_pkg::PIX_W-1:0]   mask_q  [mppa_pkg::NUM_CHAN];
	logic [mppa_pkg::SHIFT_W-1:0] shift_q [mppa_pkg::NUM_CHAN];
	logic [mppa_pkg::SHIFT_W-1:0] alpha_shift_q;
	logic                         mask_err_q;
	logic [mppa_pkg::PIX_W-1:0]   mask_nxt [mppa_pkg::NUM_CHAN];
	logic [mppa_pkg::PIX_W-1:0]   alpha_nxt;

	always_comb begin
		for (int i = 0; i < mppa_pkg::NUM_CHAN; i++) begin
			mask_nxt[i] = mask_q[i];
		end
		unique case (cfg_index)
			mppa_pkg::REG_RED:   mask_nxt[0] = cfg_data;
			mppa_pkg::REG_GREEN: mask_nxt[1] = cfg_data;
			mppa_pkg::REG_BLUE:  mask_nxt[2] = cfg_data;
			default: ;
		endcase
		alpha_nxt = ~(mask_nxt[0] | mask_nxt[1] | mask_nxt[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q[0]     <= mppa_pkg::RED_MASK_RST;
			mask_q[1]     <= mppa_pkg::GREEN_MASK_RST;
			mask_q[2]     <= mppa_pkg::BLUE_MASK_RST;
			shift_q[0]    <= mppa_pkg::RED_SHIFT_RST;
			shift_q[1]    <= mppa_pkg::GREEN_SHIFT_RST;
			shift_q[2]    <= mppa_pkg::BLUE_SHIFT_RST;
			alpha_shift_q <= mppa_pkg::ALPHA_SHIFT_RST;
			mask_err_q    <= 1'b0;
		end else if (cfg_we) begin
			for (int i = 0; i < mppa_pkg::NUM_CHAN; i++) begin
				mask_q[i]  <= mask_nxt[i];
				shift_q[i] <= mppa_pkg::low_bit(mask_nxt[i]);
			end
			alpha_shift_q <= mppa_pkg::low_bit(alpha_nxt);
			mask_err_q    <= (mask_nxt[0] == '0) || (mask_nxt[1] == '0) ||
			                 (mask_nxt[2] == '0) || (alpha_nxt == '0);
		end
	end

	// pipeline flow control
	logic [NS:1] valid_s;
	logic [NS:1] adv;

	always_comb begin
		adv[NS] = !valid_s[NS] || !out_stall;
		for (int i = NS - 1; i >= 1; i--) begin
			adv[i] = !valid_s[i] || adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (adv[1]) begin
				valid_s[1] <= in_valid;
			end
			for (int i = 2; i <= NS; i++) begin
				if (adv[i]) begin
					valid_s[i] <= valid_s[i-1];
				end
			end
		end
	end

	assign in_stall  = !adv[1];
	assign out_valid = valid_s[NS];

	// s1: channel extract
	logic [mppa_pkg::CHAN_W-1:0] chan_s1 [mppa_pkg::NUM_CHAN];
	logic [mppa_pkg::CHAN_W-1:0] alpha_s1;
	logic                        err_s1;
	logic [mppa_pkg::PIX_W-1:0]  sh_tmp [mppa_pkg::NUM_CHAN];
	logic [mppa_pkg::PIX_W-1:0]  sh_alpha;

	always_comb begin
		for (int i = 0; i < mppa_pkg::NUM_CHAN; i++) begin
			sh_tmp[i] = source_pixel >> shift_q[i];
		end
		sh_alpha = source_pixel >> alpha_shift_q;
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int i = 0; i < mppa_pkg::NUM_CHAN; i++) begin
				chan_s1[i] <= sh_tmp[i][mppa_pkg::CHAN_W-1:0];
			end
			alpha_s1 <= sh_alpha[mppa_pkg::CHAN_W-1:0];
			err_s1   <= mask_err_q;
		end
	end

	// s2: c * c
	logic [mppa_pkg::SQ_W-1:0]   sq_s2 [mppa_pkg::NUM_CHAN];
	logic [mppa_pkg::CHAN_W-1:0] alpha_s2;
	logic                        err_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int i = 0; i < mppa_pkg::NUM_CHAN; i++) begin
				sq_s2[i] <= mppa_pkg::SQ_W'(chan_s1[i]) * mppa_pkg::SQ_W'(chan_s1[i]);
			end
			alpha_s2 <= alpha_s1;
			err_s2   <= err_s1;
		end
	end

	// s3: 4 * c * c * a
	logic [mppa_pkg::X_W-1:0]    x_s3 [mppa_pkg::NUM_CHAN];
	logic [mppa_pkg::CHAN_W-1:0] alpha_s3;
	logic                        err_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int i = 0; i < mppa_pkg::NUM_CHAN; i++) begin
				x_s3[i] <= {(mppa_pkg::SQ_W + mppa_pkg::CHAN_W)'(sq_s2[i]) *
				            (mppa_pkg::SQ_W + mppa_pkg::CHAN_W)'(alpha_s2), 2'b00};
			end
			alpha_s3 <= alpha_s2;
			err_s3   <= err_s2;
		end
	end

	// s4..: root stages, alpha and error ride alongside
	logic [mppa_pkg::CHAN_W-1:0] alpha_sn [FS+1:NS];
	logic                        err_sn   [FS+1:NS];
	logic [mppa_pkg::CHAN_W-1:0] root_n   [mppa_pkg::NUM_CHAN];

	always_ff @(posedge clk) begin
		if (adv[FS+1]) begin
			alpha_sn[FS+1] <= alpha_s3;
			err_sn[FS+1]   <= err_s3;
		end
		for (int i = FS + 2; i <= NS; i++) begin
			if (adv[i]) begin
				alpha_sn[i] <= alpha_sn[i-1];
				err_sn[i]   <= err_sn[i-1];
			end
		end
	end

	for (genvar c = 0; c < mppa_pkg::NUM_CHAN; c++) begin : g_chan
		mppa_root_pipe u_root (
			.clk    (clk),
			.adv    (adv[NS:FS+1]),
			.x      (x_s3[c]),
			.root_n (root_n[c])
		);
	end

	assign packed_pixel = {alpha_sn[NS], root_n[0], root_n[1], root_n[2]};
	assign mask_error   = err_sn[NS];

	// checks
	logic [mppa_pkg::PIX_W-1:0] alpha_mask_chk;
	assign alpha_mask_chk = ~(mask_q[0] | mask_q[1] | mask_q[2]);

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&valid_s) && out_stall)
		else $error("input stalled while pipeline has room");

	a_err_matches_masks: assert property (@(posedge clk) disable iff (!arst_n)
		mask_err_q == ((mask_q[0] == '0) || (mask_q[1] == '0) ||
		               (mask_q[2] == '0) || (alpha_mask_chk == '0)))
		else $error("mask error flag out of step with masks");

	a_alpha_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(alpha_mask_chk != '0) |-> alpha_mask_chk[alpha_shift_q])
		else $error("alpha shift does not point at a set mask bit");

	a_zero_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (packed_pixel[31:24] == '0) |-> (packed_pixel[23:0] == '0))
		else $error("color nonzero with zero alpha");

endmodule

// ===== sv/mppa_root_pipe.sv =====
// ----------------------------------------------------------------------------
// mppa_root_pipe
// Pipelined digit-by-digit root: finds the largest m with 255*m*m <= x,
// two result bits per stage (one in the last), then rounds to n = (m + 1) / 2.
// ----------------------------------------------------------------------------
module mppa_root_pipe (
	input  logic                                clk,
	input  logic [mppa_pkg::ROOT_STAGES-1:0]    adv,
	input  logic [mppa_pkg::X_W-1:0]            x,
	output logic [mppa_pkg::CHAN_W-1:0]         root_n
);

	typedef struct packed {
		logic [mppa_pkg::X_W-1:0]    rem;
		logic [mppa_pkg::ROOT_W-1:0] root;
	} root_state_t;

	function automatic root_state_t root_step(root_state_t s, int unsigned k);
		logic [mppa_pkg::X_W-1:0] d;
		logic [mppa_pkg::X_W-1:0] w;
		root_state_t              r;
		d = (mppa_pkg::X_W'(s.root) << (k + 1)) | (mppa_pkg::X_W'(1) << (2 * k));
		// 255 * d
		w = (d << mppa_pkg::CHAN_W) - d;
		r = s;
		if (s.rem >= w) begin
			r.rem  = s.rem - w;
			r.root = s.root | (mppa_pkg::ROOT_W'(1) << k);
		end
		return r;
	endfunction

	root_state_t root_s [mppa_pkg::ROOT_STAGES-1];

	for (genvar s = 0; s < mppa_pkg::ROOT_STAGES; s++) begin : g_stage
		root_state_t cur;

		always_comb begin
			if (s == 0) begin
				cur = '{rem: x, root: '0};
			end else begin
				cur = root_s[(s == 0) ? 0 : s - 1];
			end
			for (int j = 0; j < mppa_pkg::ROOT_PER_STAGE; j++) begin
				if (s * mppa_pkg::ROOT_PER_STAGE + j < mppa_pkg::ROOT_W) begin
					cur = root_step(cur, mppa_pkg::ROOT_W - 1 - (s * mppa_pkg::ROOT_PER_STAGE + j));
				end
			end
		end

		if (s < mppa_pkg::ROOT_STAGES - 1) begin : g_mid
			always_ff @(posedge clk) begin
				if (adv[s]) begin
					root_s[s] <= cur;
				end
			end
		end else begin : g_last
			logic [mppa_pkg::ROOT_W:0] rnd;

			assign rnd = {1'b0, cur.root} + (mppa_pkg::ROOT_W + 1)'(1);

			always_ff @(posedge clk) begin
				if (adv[s]) begin
					root_n <= rnd[mppa_pkg::CHAN_W:1];
				end
			end
		end
	end

endmodule

// ===== verif/mppa_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mppa_result_checker
// Watches the mask register port and both item channels of the masked-pixel
// premultiplier, predicts each packed ARGB item from its own copy of the
// masks and checks the results in order, field by field.
// ----------------------------------------------------------------------------
module mppa_result_checker
	import mppa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [PIX_W-1:0]  cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [PIX_W-1:0]  source_pixel,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [PIX_W-1:0]  packed_pixel,
	input  logic              mask_error,
	output int unsigned       mismatch_count,
	output int unsigned       pixels_in_flight
);

	typedef struct packed {
		logic [PIX_W-1:0] packed_pixel;
		logic             mask_error;
	} argb_result_t;

	logic [PIX_W-1:0] red_mask;
	logic [PIX_W-1:0] green_mask;
	logic [PIX_W-1:0] blue_mask;
	argb_result_t     expected_pixels[$];

	// {found, index} of the lowest set bit
	function automatic logic [SHIFT_W:0] first_one(input logic [PIX_W-1:0] m);
		for (int i = 0; i < PIX_W; i++) begin
			if (m[i]) begin
				return {1'b1, SHIFT_W'(i)};
			end
		end
		return '0;
	endfunction

	// largest n with 255 * (2n - 1)^2 <= 4 * c * c * a, i.e. half-up round of
	// sqrt(c * c * a / 255)
	function automatic logic [CHAN_W-1:0] gamma_premul(input logic [CHAN_W-1:0] c,
			input logic [CHAN_W-1:0] a);
		longint unsigned lhs;
		longint unsigned odd;
		logic [CHAN_W-1:0] n;
		lhs = 4 * longint'(c) * longint'(c) * longint'(a);
		n = '0;
		for (int k = 1; k <= 255; k++) begin
			odd = 2 * k - 1;
			if (255 * odd * odd <= lhs) begin
				n = CHAN_W'(k);
			end
		end
		return n;
	endfunction

	function automatic argb_result_t expected_pixel(input logic [PIX_W-1:0] px);
		logic [SHIFT_W:0]  pos_r, pos_g, pos_b, pos_a;
		logic [CHAN_W-1:0] a, r, g, b;
		argb_result_t      res;
		pos_r = first_one(red_mask);
		pos_g = first_one(green_mask);
		pos_b = first_one(blue_mask);
		pos_a = first_one(~(red_mask | green_mask | blue_mask));
		a = CHAN_W'(px >> pos_a[SHIFT_W-1:0]);
		r = gamma_premul(CHAN_W'(px >> pos_r[SHIFT_W-1:0]), a);
		g = gamma_premul(CHAN_W'(px >> pos_g[SHIFT_W-1:0]), a);
		b = gamma_premul(CHAN_W'(px >> pos_b[SHIFT_W-1:0]), a);
		res.packed_pixel = {a, r, g, b};
		res.mask_error = !(pos_r[SHIFT_W] && pos_g[SHIFT_W] && pos_b[SHIFT_W] &&
			pos_a[SHIFT_W]);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		argb_result_t want;
		if (!arst_n) begin
			red_mask = RED_MASK_RST;
			green_mask = GREEN_MASK_RST;
			blue_mask = BLUE_MASK_RST;
			expected_pixels.delete();
			mismatch_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected item: packed_pixel %h mask_error %b",
						packed_pixel, mask_error);
					mismatch_count++;
				end else begin
					want = expected_pixels.pop_front();
					if (packed_pixel !== want.packed_pixel) begin
						$error("packed_pixel: expected %h, got %h",
							want.packed_pixel, packed_pixel);
						mismatch_count++;
					end
					if (mask_error !== want.mask_error) begin
						$error("mask_error: expected %b, got %b",
							want.mask_error, mask_error);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				expected_pixels.push_back(expected_pixel(source_pixel));
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_RED: begin
						red_mask = cfg_data;
					end
					REG_GREEN: begin
						green_mask = cfg_data;
					end
					REG_BLUE: begin
						blue_mask = cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
		pixels_in_flight = expected_pixels.size();
	end

endmodule

// ===== verif/mask_pixel_premultiply_alpha_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mask_pixel_premultiply_alpha_tb
// Drives corner pixels and random pixel streams through the premultiplier
// under a series of mask layouts (default, swapped lanes, empty, full,
// single-bit and random), with random idling on both channels; the checker
// predicts and compares every item.
// ----------------------------------------------------------------------------
module mask_pixel_premultiply_alpha_tb;
	import mppa_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int NUM_PHASES      = 13;
	localparam int ITEMS_PER_PHASE = 87;
	localparam int QUIET_PHASE     = 6;
	localparam int DRAIN_CYCLES    = 20;

	localparam logic [PIX_W-1:0] CORNER_PIXELS [14] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_0000, 32'h00FF_FFFF,
		32'hFFFF_0000, 32'hFF00_FF00, 32'hFF00_00FF, 32'h01FF_FFFF,
		32'h8080_8080, 32'h7F7F_7F7F, 32'hFE01_0101, 32'h1020_3040,
		32'hAA55_AA55, 32'h55AA_55AA
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = REG_RED;
	logic [PIX_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [PIX_W-1:0] source_pixel = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [PIX_W-1:0] packed_pixel;
	logic             mask_error;
	logic             quiet = 1'b0;
	int unsigned      mismatch_count;
	int unsigned      pixels_in_flight;

	mask_pixel_premultiply_alpha dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.source_pixel (source_pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.packed_pixel (packed_pixel),
		.mask_error   (mask_error)
	);

	mppa_result_checker result_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.source_pixel     (source_pixel),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.packed_pixel     (packed_pixel),
		.mask_error       (mask_error),
		.mismatch_count   (mismatch_count),
		.pixels_in_flight (pixels_in_flight)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(0, 99) < 33);
	end

	function automatic logic [PIX_W-1:0] random_pixel();
		case ($urandom_range(0, 15))
			0: begin
				return '1;
			end
			1: begin
				return '0;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] px);
		while (!quiet && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		source_pixel <= px;
		do @(posedge clk); while (in_stall);
	endtask

	// leaves cfg_we high; the caller lowers it after the last write
	task automatic write_mask(input logic [1:0] index, input logic [PIX_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		do @(posedge clk); while (pixels_in_flight != 0);
	endtask

	initial begin
		logic [PIX_W-1:0] red_m, green_m, blue_m;
		int unsigned      lanes[4];
		int unsigned      pick, tmp;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (CORNER_PIXELS[i]) begin
			send_pixel(CORNER_PIXELS[i]);
		end
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain_pipeline();
			case (phase)
				0: begin
					red_m = RED_MASK_RST;
					green_m = GREEN_MASK_RST;
					blue_m = BLUE_MASK_RST;
				end
				1: begin
					red_m = 32'h0000_00FF;
					green_m = 32'h0000_FF00;
					blue_m = 32'h00FF_0000;
				end
				2: begin
					red_m = '0;
					green_m = '0;
					blue_m = '0;
				end
				3: begin
					red_m = '1;
					green_m = '1;
					blue_m = '1;
				end
				4: begin
					red_m = 32'h8000_0000;
					green_m = 32'h0000_0001;
					blue_m = 32'h4000_0000;
				end
				default: begin
					case ((phase - 5) % 4)
						0: begin
							lanes = '{0, 1, 2, 3};
							for (int i = 3; i > 0; i--) begin
								pick = $urandom_range(0, i);
								tmp = lanes[i];
								lanes[i] = lanes[pick];
								lanes[pick] = tmp;
							end
							red_m = 32'hFF << (8 * lanes[0]);
							green_m = 32'hFF << (8 * lanes[1]);
							blue_m = 32'hFF << (8 * lanes[2]);
						end
						1: begin
							red_m = $urandom;
							green_m = $urandom;
							blue_m = $urandom;
						end
						2: begin
							red_m = 32'hFF << $urandom_range(0, 31);
							green_m = 32'hFF << $urandom_range(0, 31);
							blue_m = 32'hFF << $urandom_range(0, 31);
						end
						default: begin
							red_m = $urandom;
							green_m = $urandom;
							blue_m = $urandom;
							case ($urandom_range(0, 2))
								0: red_m = '0;
								1: green_m = '0;
								default: blue_m = '0;
							endcase
						end
					endcase
				end
			endcase
			write_mask(REG_RED, red_m);
			write_mask(REG_GREEN, green_m);
			write_mask(REG_BLUE, blue_m);
			if (phase == QUIET_PHASE) begin
				write_mask(REG_UNUSED, $urandom);
			end
			cfg_we <= 1'b0;
			quiet = (phase == QUIET_PHASE);
			repeat (ITEMS_PER_PHASE) begin
				send_pixel(random_pixel());
			end
		end
		drain_pipeline();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/mppa_pkg.sv
sv/mppa_root_pipe.sv
sv/mask_pixel_premultiply_alpha.sv
verif/mppa_result_checker.sv
verif/mask_pixel_premultiply_alpha_tb.sv
